FILE: design/cel_pkg.sv
// package of shared types and constants for the circular event log
`default_nettype none
package cel_pkg;

  localparam int SLOTS_DEF   = 10;
  localparam int SLOTS_MAX   = 256;
  localparam int SLOT_W_MAX  = 8;
  localparam int IDX_W       = 4;
  localparam int TIME_W      = 64;
  localparam int GEAR_W      = 16;
  localparam int SPEED_W     = 16;
  localparam int RECORD_W    = TIME_W + GEAR_W + SPEED_W;
  localparam int COUNT_W     = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } cel_op_t;

  typedef struct packed {
    cel_op_t                 op;
    logic [SLOT_W_MAX-1:0]   addr;
    logic                    entry_valid;
    logic [RECORD_W-1:0]     record;
    logic [COUNT_W-1:0]      count;
  } cel_cmd_t;

  typedef struct packed {
    logic     valid;
    cel_cmd_t cmd;
  } cel_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cel_qstat_t;

endpackage
`default_nettype wire

FILE: design/cel_if.sv
// handshake interfaces for the input and result channels
`default_nettype none
interface cel_in_if
  import cel_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [TIME_W-1:0]   time_text;
  logic [GEAR_W-1:0]   gear_text;
  logic [SPEED_W-1:0]  speed_text;
  logic [IDX_W-1:0]    entry_index;

  modport source (output valid, kind, time_text, gear_text, speed_text, entry_index,
                  input ready);
  modport sink   (input valid, kind, time_text, gear_text, speed_text, entry_index,
                  output ready);
endinterface

interface cel_out_if
  import cel_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   rec_time;
  logic [GEAR_W-1:0]   rec_gear;
  logic [SPEED_W-1:0]  rec_speed;
  logic                entry_valid;
  logic [COUNT_W-1:0]  logged_events;

  modport source (output valid, rec_time, rec_gear, rec_speed, entry_valid, logged_events,
                  input ready);
  modport sink   (input valid, rec_time, rec_gear, rec_speed, entry_valid, logged_events,
                  output ready);
endinterface
`default_nettype wire

FILE: design/circular_event_log.sv
// Circular event log: keeps the last SLOTS records (time, gear and speed text) in a ring
// memory and answers one result beat per input beat: a store writes at the write slot, a
// read returns the entry counted from the oldest record with a valid flag, a clear empties
// the log; every result carries the saturating event count. One beat is accepted per cycle
// while the two-entry command queue has room; a result passes through the queue, the
// registered ram read and the output register, and holds there until out_ch.ready. The
// ram holds one record per slot and is not cleared; reads are only issued for held records.
`default_nettype none
module circular_event_log
  import cel_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cel_in_if.sink     in_ch,
  cel_out_if.source  out_ch
);

  cel_push_t  push;
  cel_qstat_t qstat;
  cel_cmd_t   head;
  logic       pop;

  cel_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .qstat (qstat),
    .push  (push)
  );

  cel_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .qstat (qstat),
    .pop   (pop),
    .head  (head)
  );

  cel_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .qstat  (qstat),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

FILE: design/cel_ram.sv
// generic single write port ram with registered read
`default_nettype none
module cel_ram
  import cel_pkg::*;
#(
  parameter int WIDTH = RECORD_W,
  parameter int DEPTH = SLOTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: design/cel_front.sv
// front end: accepts beats, keeps slot and count, classifies into commands
`default_nettype none
module cel_front
  import cel_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  cel_in_if.sink          in_ch,
  input  wire cel_qstat_t qstat,
  output      cel_push_t  push
);

  localparam int SW = $clog2(SLOTS);
  localparam int AW = (SW > IDX_W) ? SW : IDX_W;
  localparam logic [COUNT_W-1:0] SLOTS_CNT = COUNT_W'(SLOTS);
  localparam logic [AW:0]        SLOTS_SUM = (AW + 1)'(SLOTS);
  localparam logic [SW-1:0]      LAST_SLOT = SW'(SLOTS - 1);

  logic [SW-1:0]      wslot_r, wslot_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic               accept;
  logic               ring_full;
  logic               idx_ok;
  logic [SW-1:0]      oldest;
  logic [AW:0]        sum;
  logic [AW:0]        rd_sum;
  cel_cmd_t           cmd;

  assign in_ch.ready = !qstat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign ring_full   = total_r >= SLOTS_CNT;
  assign idx_ok      = (COUNT_W'(in_ch.entry_index) < total_r) &&
                       ((AW + 1)'(in_ch.entry_index) < SLOTS_SUM);
  assign oldest      = ring_full ? wslot_r : '0;
  assign sum         = (AW + 1)'(oldest) + (AW + 1)'(in_ch.entry_index);
  assign rd_sum      = (sum >= SLOTS_SUM) ? (sum - SLOTS_SUM) : sum;

  always_comb begin
    wslot_nxt       = wslot_r;
    total_nxt       = total_r;
    cmd.op          = OP_NONE;
    cmd.addr        = '0;
    cmd.entry_valid = 1'b0;
    cmd.record      = {in_ch.time_text, in_ch.gear_text, in_ch.speed_text};
    case (in_ch.kind)
      KIND_STORE: begin
        cmd.op    = OP_WRITE;
        cmd.addr  = SLOT_W_MAX'(wslot_r);
        wslot_nxt = (wslot_r == LAST_SLOT) ? '0 : wslot_r + SW'(1);
        total_nxt = (total_r == COUNT_MAX) ? total_r : total_r + COUNT_W'(1);
      end
      KIND_READ: begin
        if (idx_ok) begin
          cmd.op          = OP_READ;
          cmd.addr        = SLOT_W_MAX'(rd_sum[SW-1:0]);
          cmd.entry_valid = 1'b1;
        end
      end
      KIND_CLEAR: begin
        wslot_nxt = '0;
        total_nxt = '0;
      end
      default: begin
        cmd.op = OP_NONE;
      end
    endcase
    cmd.count = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r <= '0;
      total_r <= '0;
    end else if (accept) begin
      wslot_r <= wslot_nxt;
      total_r <= total_nxt;
    end
  end

  assign push.valid = accept;
  assign push.cmd   = cmd;

endmodule
`default_nettype wire

FILE: design/cel_queue.sv
// short command queue between front and back end
`default_nettype none
module cel_queue
  import cel_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cel_push_t push,
  output      cel_qstat_t qstat,
  input  wire logic      pop,
  output      cel_cmd_t  head
);

  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QC_W-1:0] Q_FULL = QC_W'(QUEUE_DEPTH);

  cel_cmd_t        q_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;

  assign qstat.full  = count_r == Q_FULL;
  assign qstat.empty = count_r == '0;
  assign head        = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push.valid ? wr_ptr_r + QP_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QP_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + QC_W'(1);
    end else if (pop && !push.valid) begin
      count_nxt = count_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q_r[wr_ptr_r] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !qstat.full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty) else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && !pop) |=> count_r == $past(count_r) + QC_W'(1))
    else $error("queue count lost a push");
`endif

endmodule
`default_nettype wire

FILE: design/cel_back.sv
// back end: carries out ram accesses and holds the result beat
`default_nettype none
module cel_back
  import cel_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cel_qstat_t qstat,
  input  wire cel_cmd_t   head,
  output      logic       pop,
  cel_out_if.source       out_ch
);

  localparam int SW = $clog2(SLOTS);

  logic                s1_valid_r;
  logic                s1_evalid_r;
  logic [COUNT_W-1:0]  s1_count_r;
  logic                s1_move;
  logic                out_valid_r;
  logic [TIME_W-1:0]   out_time_r;
  logic [GEAR_W-1:0]   out_gear_r;
  logic [SPEED_W-1:0]  out_speed_r;
  logic                out_evalid_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [RECORD_W-1:0] rdata;
  logic [RECORD_W-1:0] rec;
  logic                ram_we;
  logic                ram_re;

  assign s1_move = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign pop     = !qstat.empty && (!s1_valid_r || s1_move);
  assign ram_we  = pop && (head.op == OP_WRITE);
  assign ram_re  = pop && (head.op == OP_READ);
  assign rec     = s1_evalid_r ? rdata : '0;

  cel_ram #(
    .WIDTH (RECORD_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.addr[SW-1:0]),
    .wdata (head.record),
    .re    (ram_re),
    .raddr (head.addr[SW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_evalid_r <= head.entry_valid;
      s1_count_r  <= head.count;
    end
    if (s1_move) begin
      out_time_r   <= rec[RECORD_W-1 -: TIME_W];
      out_gear_r   <= rec[SPEED_W +: GEAR_W];
      out_speed_r  <= rec[SPEED_W-1:0];
      out_evalid_r <= s1_evalid_r;
      out_count_r  <= s1_count_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.rec_time      = out_time_r;
  assign out_ch.rec_gear      = out_gear_r;
  assign out_ch.rec_speed     = out_speed_r;
  assign out_ch.entry_valid   = out_evalid_r;
  assign out_ch.logged_events = out_count_r;

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// testbench for the circular event log: a directed table then random beats against a predictor
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cel_pkg::*;

  localparam int LOG_SLOTS = SLOTS_DEF;
  localparam int RANDOM_ITEMS = 1925;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef struct packed {
    logic [1:0]         kind;
    logic [TIME_W-1:0]  time_text;
    logic [GEAR_W-1:0]  gear_text;
    logic [SPEED_W-1:0] speed_text;
    logic [IDX_W-1:0]   entry_index;
  } log_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]  rec_time;
    logic [GEAR_W-1:0]  rec_gear;
    logic [SPEED_W-1:0] rec_speed;
    logic               entry_valid;
    logic [COUNT_W-1:0] logged_events;
  } log_result_t;

  typedef struct packed {
    log_item_t   item;
    logic        fixed;
    log_result_t want;
  } log_row_t;

  logic clk = 1'b0;
  logic rst_n;

  cel_in_if  in_ch ();
  cel_out_if out_ch ();

  circular_event_log #(.SLOTS(LOG_SLOTS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [TIME_W-1:0]  ring_time  [LOG_SLOTS];
  logic [GEAR_W-1:0]  ring_gear  [LOG_SLOTS];
  logic [SPEED_W-1:0] ring_speed [LOG_SLOTS];
  int unsigned        write_slot;
  logic [COUNT_W-1:0] event_total;

  log_result_t awaited_results[$];
  log_row_t    directed_rows[$];
  log_result_t oldest_awaited;
  int unsigned failures;
  int unsigned results_seen;
  int unsigned burst_left;

  function automatic log_item_t mk_item(logic [1:0] kind, logic [TIME_W-1:0] t,
                                        logic [GEAR_W-1:0] g, logic [SPEED_W-1:0] s,
                                        logic [IDX_W-1:0] idx);
    log_item_t it;
    it.kind        = kind;
    it.time_text   = t;
    it.gear_text   = g;
    it.speed_text  = s;
    it.entry_index = idx;
    return it;
  endfunction

  function automatic log_result_t mk_result(logic [TIME_W-1:0] t, logic [GEAR_W-1:0] g,
                                            logic [SPEED_W-1:0] s, logic v,
                                            logic [COUNT_W-1:0] cnt);
    log_result_t r;
    r.rec_time      = t;
    r.rec_gear      = g;
    r.rec_speed     = s;
    r.entry_valid   = v;
    r.logged_events = cnt;
    return r;
  endfunction

  task automatic add_row(log_item_t it, logic fixed, log_result_t want);
    log_row_t row;
    row.item  = it;
    row.fixed = fixed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  function automatic int unsigned held_records();
    return (event_total < LOG_SLOTS) ? int'(event_total) : LOG_SLOTS;
  endfunction

  // applies one beat to the ring and returns what the log answers
  function automatic log_result_t log_access(log_item_t it);
    log_result_t r;
    int unsigned oldest;
    int unsigned slot;
    r = '0;
    case (it.kind)
      KIND_STORE: begin
        ring_time[write_slot]  = it.time_text;
        ring_gear[write_slot]  = it.gear_text;
        ring_speed[write_slot] = it.speed_text;
        write_slot = (write_slot + 1 >= LOG_SLOTS) ? 0 : write_slot + 1;
        if (event_total != COUNT_MAX) event_total = event_total + 1'b1;
      end
      KIND_READ: begin
        if (it.entry_index < held_records()) begin
          oldest = (event_total < LOG_SLOTS) ? 0 : write_slot;
          slot = (oldest + it.entry_index) % LOG_SLOTS;
          r.rec_time    = ring_time[slot];
          r.rec_gear    = ring_gear[slot];
          r.rec_speed   = ring_speed[slot];
          r.entry_valid = 1'b1;
        end
      end
      KIND_CLEAR: begin
        event_total = '0;
        write_slot  = 0;
      end
      default: ;
    endcase
    r.logged_events = event_total;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] clock_text();
    logic [7:0] hh;
    logic [7:0] mm;
    logic [7:0] ss;
    hh = 8'($urandom_range(0, 23));
    mm = 8'($urandom_range(0, 59));
    ss = 8'($urandom_range(0, 59));
    return {8'(ASCII_ZERO + hh / 10), 8'(ASCII_ZERO + hh % 10), ":",
            8'(ASCII_ZERO + mm / 10), 8'(ASCII_ZERO + mm % 10), ":",
            8'(ASCII_ZERO + ss / 10), 8'(ASCII_ZERO + ss % 10)};
  endfunction

  function automatic log_item_t random_item();
    log_item_t   it;
    int unsigned pick;
    int unsigned held;
    logic [7:0]  gear_letter;
    pick = $urandom_range(0, 99);
    held = held_records();
    it.kind = (pick < 50) ? KIND_STORE :
              (pick < 95) ? KIND_READ  :
              (pick < 98) ? KIND_CLEAR : KIND_UNUSED;
    case ($urandom_range(0, 3))
      0:       gear_letter = "P";
      1:       gear_letter = "R";
      2:       gear_letter = "N";
      default: gear_letter = "D";
    endcase
    if ($urandom_range(0, 9) == 0) begin
      it.time_text  = {$urandom, $urandom};
      it.gear_text  = 16'($urandom);
      it.speed_text = 16'($urandom);
    end else begin
      it.time_text  = clock_text();
      it.gear_text  = {gear_letter, ASCII_ZERO + 8'($urandom_range(0, 6))};
      it.speed_text = {ASCII_ZERO + 8'($urandom_range(0, 9)),
                       ASCII_ZERO + 8'($urandom_range(0, 9))};
    end
    if ($urandom_range(0, 3) == 0 || held == 0)
      it.entry_index = 4'($urandom_range(0, 15));
    else
      it.entry_index = 4'($urandom_range(0, held));
    return it;
  endfunction

  task automatic report_failure(string what);
    $display("[%0t] error: %s", $realtime, what);
    failures++;
  endtask

  // one beat on the input channel; the expectation is taken at the accepting edge
  task automatic send_beat(log_row_t row);
    log_result_t predicted;
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= row.item.kind;
    in_ch.time_text   <= row.item.time_text;
    in_ch.gear_text   <= row.item.gear_text;
    in_ch.speed_text  <= row.item.speed_text;
    in_ch.entry_index <= row.item.entry_index;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predicted = log_access(row.item);
    awaited_results.push_back(row.fixed ? row.want : predicted);
  endtask

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        report_failure($sformatf("result beat %0d with nothing awaited", results_seen));
      end else begin
        oldest_awaited = awaited_results.pop_front();
        if (out_ch.rec_time !== oldest_awaited.rec_time)
          report_failure($sformatf("beat %0d rec_time %h, want %h", results_seen,
                                   out_ch.rec_time, oldest_awaited.rec_time));
        if (out_ch.rec_gear !== oldest_awaited.rec_gear)
          report_failure($sformatf("beat %0d rec_gear %h, want %h", results_seen,
                                   out_ch.rec_gear, oldest_awaited.rec_gear));
        if (out_ch.rec_speed !== oldest_awaited.rec_speed)
          report_failure($sformatf("beat %0d rec_speed %h, want %h", results_seen,
                                   out_ch.rec_speed, oldest_awaited.rec_speed));
        if (out_ch.entry_valid !== oldest_awaited.entry_valid)
          report_failure($sformatf("beat %0d entry_valid %b, want %b", results_seen,
                                   out_ch.entry_valid, oldest_awaited.entry_valid));
        if (out_ch.logged_events !== oldest_awaited.logged_events)
          report_failure($sformatf("beat %0d logged_events %0d, want %0d", results_seen,
                                   out_ch.logged_events, oldest_awaited.logged_events));
      end
      results_seen++;
    end
  end

  initial begin : receiver_pattern
    int unsigned mode;
    int unsigned stretch;
    logic        level;
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      case (mode)
        0:       stretch = $urandom_range(10, 40);
        2:       stretch = $urandom_range(1, 12);
        default: stretch = $urandom_range(4, 20);
      endcase
      repeat (stretch) begin
        case (mode)
          0:       level = 1'b1;
          1:       level = 1'($urandom_range(0, 1));
          2:       level = 1'b0;
          default: level = ($urandom_range(0, 3) != 0);
        endcase
        out_ch.ready <= level;
        @(posedge clk);
      end
    end
  end

  initial begin : run_limit
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    log_row_t row;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_STORE;
    in_ch.time_text   = '0;
    in_ch.gear_text   = '0;
    in_ch.speed_text  = '0;
    in_ch.entry_index = '0;
    failures          = 0;
    results_seen      = 0;
    burst_left        = 0;
    write_slot        = 0;
    event_total       = '0;

    // empty log, extremes, unused kind and clear
    add_row(mk_item(KIND_READ, '0, '0, '0, 4'd0), 1'b1, mk_result('0, '0, '0, 1'b0, 0));
    add_row(mk_item(KIND_STORE, '1, '1, '1, 4'd15), 1'b1, mk_result('0, '0, '0, 1'b0, 1));
    add_row(mk_item(KIND_STORE, '0, '0, '0, 4'd0), 1'b1, mk_result('0, '0, '0, 1'b0, 2));
    add_row(mk_item(KIND_READ, '0, '0, '0, 4'd0), 1'b1, mk_result('1, '1, '1, 1'b1, 2));
    add_row(mk_item(KIND_READ, '1, '1, '1, 4'd1), 1'b1, mk_result('0, '0, '0, 1'b1, 2));
    add_row(mk_item(KIND_READ, '0, '0, '0, 4'd2), 1'b1, mk_result('0, '0, '0, 1'b0, 2));
    add_row(mk_item(KIND_READ, '1, '1, '1, 4'd15), 1'b1, mk_result('0, '0, '0, 1'b0, 2));
    add_row(mk_item(KIND_UNUSED, '1, '1, '1, 4'd0), 1'b1, mk_result('0, '0, '0, 1'b0, 2));
    add_row(mk_item(KIND_CLEAR, '1, '1, '1, 4'd0), 1'b1, mk_result('0, '0, '0, 1'b0, 0));
    add_row(mk_item(KIND_READ, '0, '0, '0, 4'd0), 1'b1, mk_result('0, '0, '0, 1'b0, 0));
    // fill past the ring size so the oldest moves to the write slot
    for (int i = 0; i < LOG_SLOTS + 1; i++)
      add_row(mk_item(KIND_STORE, {"08:15:", ASCII_ZERO + 8'(i / 10), ASCII_ZERO + 8'(i % 10)},
                      "D4", {"6", ASCII_ZERO + 8'(i % 10)}, 4'd0), 1'b0, '0);
    add_row(mk_item(KIND_READ, '0, '0, '0, 4'd0), 1'b0, '0);
    add_row(mk_item(KIND_READ, '0, '0, '0, 4'(LOG_SLOTS - 1)), 1'b0, '0);
    add_row(mk_item(KIND_READ, '0, '0, '0, 4'(LOG_SLOTS)), 1'b0, '0);
    add_row(mk_item(KIND_CLEAR, '0, '0, '0, 4'd0), 1'b1, mk_result('0, '0, '0, 1'b0, 0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      pace_sender();
      send_beat(directed_rows[i]);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        in_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
      end
      pace_sender();
      row.item  = random_item();
      row.fixed = 1'b0;
      row.want  = '0;
      send_beat(row);
    end

    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
design/cel_pkg.sv
design/cel_if.sv
design/cel_ram.sv
design/cel_front.sv
design/cel_queue.sv
design/cel_back.sv
design/circular_event_log.sv
bench/testbench.sv
